/* design/kdcd_pkg.sv */
// kdcd_pkg: types, constants and register codes shared by the key debounce and click detector
// no dependencies
`default_nettype none

package kdcd_pkg;

   // keys that reach the result fields
   localparam int MAX_KEYS     = 8;
   localparam int NUM_KEYS_DEF = 8;
   localparam int STATE_W      = 3;
   localparam int STATES_W     = MAX_KEYS * STATE_W;
   localparam int TIME_W       = 32;
   localparam int CNT_W        = 8;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 5;

   localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

   // register reset values
   localparam logic [CNT_W-1:0]  DEBOUNCE_RST = 8'd3;
   localparam logic [TIME_W-1:0] REPEAT_RST   = 32'd1000000;
   localparam logic [TIME_W-1:0] WINDOW_RST   = 32'd300000;
   localparam logic [TIME_W-1:0] GAP_RST      = 32'd500000;
   localparam logic              DBL_EN_RST   = 1'b1;

   typedef enum logic [STATE_W-1:0] {
      MODE_IDLE   = 3'd0,
      MODE_DOWN   = 3'd1,
      MODE_WAIT   = 3'd2,
      MODE_CLICK  = 3'd3,
      MODE_REPEAT = 3'd4,
      MODE_DBL    = 3'd5,
      MODE_DBLUP  = 3'd6
   } key_mode_type;

   typedef enum logic [2:0] {
      CSR_DEBOUNCE = 3'd0,
      CSR_REPEAT   = 3'd1,
      CSR_WINDOW   = 3'd2,
      CSR_GAP      = 3'd3,
      CSR_DBL_EN   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CNT_W-1:0]  debounce_count;
      logic [TIME_W-1:0] repeat_time_us;
      logic [TIME_W-1:0] double_window_us;
      logic [TIME_W-1:0] double_gap_us;
      logic              double_enable;
   } kdcd_cfg_type;

   // next-state view of one lane, taken by the merging stage
   typedef struct packed {
      key_mode_type mode;
      logic         pending;
   } lane_stat_type;

endpackage

`default_nettype wire

/* design/kdcd_req_if.sv */
// kdcd_req_if: request channel (scan tick) with valid/ready handshake
// depends on kdcd_pkg
`default_nettype none

interface kdcd_req_if;
   logic                            valid;
   logic                            ready;
   logic [kdcd_pkg::MAX_KEYS-1:0]   pressed_mask;
   logic [kdcd_pkg::MAX_KEYS-1:0]   ack_mask;
   logic [kdcd_pkg::TIME_W-1:0]     now_us;

   modport source (output valid, output pressed_mask, output ack_mask, output now_us,
                   input ready);
   modport sink (input valid, input pressed_mask, input ack_mask, input now_us,
                 output ready);
endinterface

`default_nettype wire

/* design/kdcd_rsp_if.sv */
// kdcd_rsp_if: result channel (key states and event flags) with valid/ready handshake
// depends on kdcd_pkg
`default_nettype none

interface kdcd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [kdcd_pkg::STATES_W-1:0]   key_states;
   logic [kdcd_pkg::MAX_KEYS-1:0]   new_event_mask;

   modport source (output valid, output key_states, output new_event_mask, input ready);
   modport sink (input valid, input key_states, input new_event_mask, output ready);
endinterface

`default_nettype wire

/* design/kdcd_csr.sv */
// kdcd_csr: configuration registers behind an apb-style write/read port
// depends on kdcd_pkg
`default_nettype none

module kdcd_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [kdcd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [kdcd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [kdcd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready,
   output kdcd_pkg::kdcd_cfg_type                 cfg
);
   import kdcd_pkg::*;

   kdcd_cfg_type  cfg_ff, cfg_in;
   logic          wr_en;
   csr_index_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = csr_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_DEBOUNCE: cfg_in.debounce_count   = pwdata[CNT_W-1:0];
            CSR_REPEAT:   cfg_in.repeat_time_us   = pwdata[TIME_W-1:0];
            CSR_WINDOW:   cfg_in.double_window_us = pwdata[TIME_W-1:0];
            CSR_GAP:      cfg_in.double_gap_us    = pwdata[TIME_W-1:0];
            CSR_DBL_EN:   cfg_in.double_enable    = pwdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_DEBOUNCE: prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, cfg_ff.debounce_count};
         CSR_REPEAT:   prdata = cfg_ff.repeat_time_us;
         CSR_WINDOW:   prdata = cfg_ff.double_window_us;
         CSR_GAP:      prdata = cfg_ff.double_gap_us;
         CSR_DBL_EN:   prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.double_enable};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_count   <= DEBOUNCE_RST;
         cfg_ff.repeat_time_us   <= REPEAT_RST;
         cfg_ff.double_window_us <= WINDOW_RST;
         cfg_ff.double_gap_us    <= GAP_RST;
         cfg_ff.double_enable    <= DBL_EN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* design/kdcd_lane.sv */
// kdcd_lane: debounce counter and click/repeat/double-press state machine for one key
// depends on kdcd_pkg
`default_nettype none

module kdcd_lane (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire logic                            pressed,
   input  wire logic                            ack,
   input  wire logic [kdcd_pkg::TIME_W-1:0]     now_us,
   input  kdcd_pkg::kdcd_cfg_type               cfg,
   output kdcd_pkg::lane_stat_type              stat
);
   import kdcd_pkg::*;

   key_mode_type      mode_ff, mode_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [TIME_W-1:0] stamp_ff, stamp_in;
   logic [TIME_W-1:0] drs_ff, drs_in;
   logic              lock_ff, lock_in;

   logic              en;
   logic              ev_ack;
   logic              cnt_zero;
   logic              cnt_ok;
   logic [TIME_W-1:0] press_el;
   logic [TIME_W-1:0] dbl_el;
   logic              window_hit;
   logic              repeat_hit_full;
   logic              repeat_hit_simple;
   logic              lock_set;
   logic              lock_cur;
   logic [TIME_W-1:0] lock_el;

   assign en       = cfg.double_enable;
   assign ev_ack   = pend_ff & ~ack;
   assign cnt_in   = !pressed ? '0 : ((cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + 1'b1);
   assign cnt_zero = (cnt_in == '0);
   assign cnt_ok   = (cnt_in >= cfg.debounce_count);
   assign press_el = now_us - stamp_ff;
   assign dbl_el   = now_us - drs_ff;

   assign window_hit        = (press_el >= cfg.double_window_us);
   // a release in down restamps, so the hold time seen then is zero
   assign repeat_hit_full   = ((cnt_zero ? '0 : press_el) >= cfg.repeat_time_us);
   assign repeat_hit_simple = (press_el >= cfg.repeat_time_us);

   // next state
   always_comb begin
      mode_in = mode_ff;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (cnt_ok) mode_in = MODE_DOWN;
         end
         MODE_DOWN: begin
            if (en) begin
               if (repeat_hit_full) mode_in = MODE_REPEAT;
               else if (cnt_zero)   mode_in = MODE_WAIT;
            end else begin
               if (repeat_hit_simple) mode_in = MODE_REPEAT;
               else if (cnt_zero)     mode_in = MODE_CLICK;
            end
         end
         MODE_WAIT: begin
            // an allowed second press wins over the click timeout
            if (en) begin
               if (!lock_ff && cnt_ok) mode_in = MODE_DBL;
               else if (window_hit)    mode_in = MODE_CLICK;
            end
         end
         MODE_CLICK: begin
            if (!ev_ack) mode_in = MODE_IDLE;
         end
         MODE_REPEAT: begin
            if (cnt_zero) mode_in = MODE_IDLE;
         end
         MODE_DBL: begin
            if (en && cnt_zero) mode_in = MODE_DBLUP;
         end
         MODE_DBLUP: begin
            if (en && !ev_ack) mode_in = MODE_IDLE;
         end
         default: mode_in = mode_ff;
      endcase
   end

   // state outputs: event flag, stamps, lock
   always_comb begin
      pend_in  = ev_ack;
      stamp_in = stamp_ff;
      drs_in   = drs_ff;
      lock_set = 1'b0;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (cnt_ok) stamp_in = now_us;
         end
         MODE_DOWN: begin
            if (en) begin
               if (cnt_zero)        stamp_in = now_us;
               if (repeat_hit_full) pend_in  = 1'b1;
            end else if (cnt_zero || repeat_hit_simple) begin
               pend_in = 1'b1;
            end
         end
         MODE_WAIT: begin
            if (en && window_hit) pend_in = 1'b1;
         end
         MODE_DBL: begin
            if (en && cnt_zero) pend_in = 1'b1;
         end
         MODE_DBLUP: begin
            if (en && !ev_ack) begin
               lock_set = 1'b1;
               drs_in   = now_us;
            end
         end
         default: pend_in = ev_ack;
      endcase
   end

   // lock timeout, only while double press is enabled
   assign lock_cur = lock_ff | lock_set;
   assign lock_el  = lock_set ? '0 : dbl_el;
   assign lock_in  = en ? (lock_cur && !(lock_el >= cfg.double_gap_us)) : lock_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
         lock_ff  <= 1'b0;
         stamp_ff <= '0;
         drs_ff   <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         lock_ff  <= lock_in;
         stamp_ff <= stamp_in;
         drs_ff   <= drs_in;
      end
   end

   assign stat.mode    = mode_in;
   assign stat.pending = pend_in;

   a_idle_press_stamps: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == MODE_IDLE && mode_in == MODE_DOWN) |=> (stamp_ff == $past(now_us)))
      else $error("press stamp not taken on accepted press");

   a_release_clears_count: assert property (@(posedge clock) disable iff (reset)
      (accept && !pressed) |=> (cnt_ff == '0))
      else $error("debounce count not cleared on release");

   a_mode_holds_between: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(mode_ff) && $stable(pend_ff) && $stable(lock_ff)))
      else $error("key state changed without a request");

endmodule

`default_nettype wire

/* design/kdcd_merge.sv */
// kdcd_merge: packs the lanes' states and flags into the registered result
// depends on kdcd_pkg, kdcd_rsp_if
`default_nettype none

module kdcd_merge #(
   parameter int NUM_LANES = kdcd_pkg::MAX_KEYS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  kdcd_pkg::lane_stat_type   stats [NUM_LANES],
   output logic                      req_ready,
   kdcd_rsp_if.source                rsp_chan
);
   import kdcd_pkg::*;

   logic                      valid_ff, valid_in;
   logic [STATES_W-1:0]       states_ff, states_in;
   logic [MAX_KEYS-1:0]       events_ff, events_in;
   logic [STATE_W-1:0]        mode_slot [MAX_KEYS];
   logic                      pend_slot [MAX_KEYS];

   for (genvar g = 0; g < MAX_KEYS; g++) begin : g_slot
      if (g < NUM_LANES) begin : g_used
         assign mode_slot[g] = stats[g].mode;
         assign pend_slot[g] = stats[g].pending;
      end else begin : g_absent
         assign mode_slot[g] = '0;
         assign pend_slot[g] = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_KEYS; i++) begin
         states_in[i*STATE_W +: STATE_W] = mode_slot[i];
         events_in[i]                    = pend_slot[i];
      end
   end

   assign req_ready = !valid_ff || rsp_chan.ready;
   assign valid_in  = accept || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         states_ff <= states_in;
         events_ff <= events_in;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.key_states     = states_ff;
   assign rsp_chan.new_event_mask = events_ff;

endmodule

`default_nettype wire

/* design/key_debounce_click_detector.sv */
// key_debounce_click_detector: per-key debounce and click, long-press and double-press detection
// a result is registered and valid in the cycle after its request is accepted
// throughput: one request per cycle; a new request is taken in the cycle the last result
// leaves, and the input stalls while a result waits on a low rsp ready
// all keys are updated in the same cycle by one lane each, so no loop sets the rate
// reset: synchronous, clears every key to idle, counters, flags and locks to zero,
// and loads the register defaults; no clearing pass
// depends on kdcd_pkg, kdcd_req_if, kdcd_rsp_if, kdcd_csr, kdcd_lane, kdcd_merge
`default_nettype none

module key_debounce_click_detector #(
   parameter int NUM_KEYS = kdcd_pkg::NUM_KEYS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   kdcd_req_if.sink                               req_chan,
   kdcd_rsp_if.source                             rsp_chan,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [kdcd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [kdcd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [kdcd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready
);
   import kdcd_pkg::*;

   // keys past the result fields always read released and never show up,
   // so only the visible keys get a lane
   localparam int NUM_LANES = (NUM_KEYS < MAX_KEYS) ? NUM_KEYS : MAX_KEYS;

   kdcd_cfg_type  cfg;
   lane_stat_type stats [NUM_LANES];
   logic          req_ready;
   logic          accept;

   // request handshake: taken whenever the output register is free or draining
   assign req_chan.ready = req_ready;
   assign accept         = req_chan.valid && req_ready;

   // configuration registers
   kdcd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // one lane per key: ack, debounce and state machine all in the accept cycle
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      kdcd_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .accept  (accept),
         .pressed (req_chan.pressed_mask[k]),
         .ack     (req_chan.ack_mask[k]),
         .now_us  (req_chan.now_us),
         .cfg     (cfg),
         .stat    (stats[k])
      );
   end

   // merging stage and output register
   kdcd_merge #(
      .NUM_LANES (NUM_LANES)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .stats     (stats),
      .req_ready (req_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
